>>> design/lpt_ma_pkg.sv
// ----------------------------------------------------------------------------
// LPT machine assigner package
// Shared types and constants for the heap-based list scheduler.
// ----------------------------------------------------------------------------
package lpt_ma_pkg;

   localparam int MACH_W           = 7;
   localparam int TIME_W           = 32;
   localparam int LEN_W            = 16;
   localparam int COUNT_W          = 7;
   localparam int COUNT_RESET      = 3;
   localparam int MAX_MACHINES_DEF = 64;

   localparam logic OP_RESTART = 1'b0;
   localparam logic OP_JOB     = 1'b1;

   typedef struct packed {
      logic [MACH_W-1:0] mach;
      logic [TIME_W-1:0] free_time;
   } slot_entry_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_POP_RD,
      ST_POP_LAT,
      ST_DN_RD,
      ST_DN_CMP,
      ST_DN_PLACE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_UP_PLACE
   } state_type;

endpackage

>>> design/lpt_machine_assigner_core.sv
// ----------------------------------------------------------------------------
// LPT machine assigner core
// Greedy list scheduler: a binary min-heap of machines keyed by free time,
// delete-min then re-insert per job, run by a small sequencer over one RAM.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  request  | req_valid/ready, opcode, job_length     | in
//  response | rsp_valid/ready, machine_id, start,     | out
//           | finish_time, overflow                   |
//  csr      | csr_we, csr_wdata (machine_count)       | in
//
//  Job: delete-min, then sift-down and sift-up over the heap levels;
//  each heap level is one RAM read plus one compare/move.
//  Restart: rewrites min(machine_count, MAX_MACHINES) slots.
//  Reset: rewrites min(3, MAX_MACHINES) slots before req_ready rises.
//  A finished result sits in the output register; the next job runs while
//  it waits and stalls only when its own result is ready to be loaded.
// ----------------------------------------------------------------------------
module lpt_machine_assigner_core #(
   parameter int MAX_MACHINES = lpt_ma_pkg::MAX_MACHINES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_opcode,
   input  logic [lpt_ma_pkg::LEN_W-1:0]        req_job_length,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [lpt_ma_pkg::MACH_W-1:0]       rsp_machine_id,
   output logic [lpt_ma_pkg::TIME_W-1:0]       rsp_start_time,
   output logic [lpt_ma_pkg::TIME_W-1:0]       rsp_finish_time,
   output logic                                rsp_overflow,
   input  logic                                csr_we,
   input  logic [lpt_ma_pkg::COUNT_W-1:0]      csr_wdata
);

   localparam int SW        = $clog2(MAX_MACHINES + 1);
   localparam int MachW     = lpt_ma_pkg::MACH_W;
   localparam int TimeW     = lpt_ma_pkg::TIME_W;
   localparam int LenW      = lpt_ma_pkg::LEN_W;
   localparam int InitReset = (lpt_ma_pkg::COUNT_RESET > MAX_MACHINES) ?
                              MAX_MACHINES : lpt_ma_pkg::COUNT_RESET;

   lpt_ma_pkg::state_type      state_ff, state_in;
   logic [lpt_ma_pkg::COUNT_W-1:0] count_ff;
   logic [SW-1:0]              fill_ff, fill_in;
   logic [SW-1:0]              init_k_ff, init_k_in;
   logic [SW-1:0]              init_n_ff, init_n_in;
   logic [SW-1:0]              parent_ff, parent_in;
   logic [SW:0]                child_ff, child_in;
   logic [SW-1:0]              up_idx_ff, up_idx_in;
   logic [LenW-1:0]            len_ff, len_in;
   logic [MachW-1:0]           mach_ff, mach_in;
   logic [TimeW-1:0]           start_ff, start_in;
   logic [TimeW-1:0]           finish_ff, finish_in;
   logic                       ovf_ff, ovf_in;
   lpt_ma_pkg::slot_entry_type last_ff, last_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [MachW-1:0]           rsp_mach_ff, rsp_mach_in;
   logic [TimeW-1:0]           rsp_start_ff, rsp_start_in;
   logic [TimeW-1:0]           rsp_finish_ff, rsp_finish_in;
   logic                       rsp_ovf_ff, rsp_ovf_in;

   lpt_ma_pkg::slot_entry_type slot_mem [MAX_MACHINES:0];
   lpt_ma_pkg::slot_entry_type rd_a_ff, rd_b_ff;
   logic [SW-1:0]              rd_addr_a, rd_addr_b, wr_addr;
   logic                       wr_en;
   lpt_ma_pkg::slot_entry_type wr_data;

   logic [SW-1:0]              restart_n;
   logic                       req_xfer;
   logic                       rsp_free;
   logic                       child_has_sib;
   logic                       pick_b;
   lpt_ma_pkg::slot_entry_type sel_entry;
   logic [SW-1:0]              sel_idx;
   logic                       dn_stop;
   logic                       up_move;
   logic [TimeW:0]             sum;

   assign restart_n = (32'(count_ff) > 32'(MAX_MACHINES)) ?
                      SW'(MAX_MACHINES) : SW'(count_ff);
   assign req_ready = (state_ff == lpt_ma_pkg::ST_IDLE);
   assign req_xfer  = req_valid & req_ready;
   assign rsp_free  = ~rsp_valid_ff | rsp_ready;

   // shared compare unit: child pick, sift-down stop, sift-up move
   assign child_has_sib = (child_ff < {1'b0, fill_ff});
   assign pick_b        = child_has_sib & (rd_b_ff.free_time < rd_a_ff.free_time);
   assign sel_entry     = pick_b ? rd_b_ff : rd_a_ff;
   assign sel_idx       = pick_b ? (child_ff[SW-1:0] + SW'(1)) : child_ff[SW-1:0];
   assign dn_stop       = (last_ff.free_time < sel_entry.free_time);
   assign up_move       = (finish_ff < rd_a_ff.free_time);
   assign sum           = {1'b0, start_ff} + (TimeW+1)'(len_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lpt_ma_pkg::ST_INIT: begin
            if (init_k_ff == init_n_ff) state_in = lpt_ma_pkg::ST_IDLE;
         end
         lpt_ma_pkg::ST_IDLE: begin
            if (req_xfer) begin
               if (req_opcode == lpt_ma_pkg::OP_RESTART) begin
                  if (restart_n != '0) state_in = lpt_ma_pkg::ST_INIT;
               end else if (fill_ff != '0) begin
                  state_in = lpt_ma_pkg::ST_POP_RD;
               end
            end
         end
         lpt_ma_pkg::ST_POP_RD:   state_in = lpt_ma_pkg::ST_POP_LAT;
         lpt_ma_pkg::ST_POP_LAT:  state_in = lpt_ma_pkg::ST_DN_RD;
         lpt_ma_pkg::ST_DN_RD: begin
            if (child_ff > {1'b0, fill_ff}) state_in = lpt_ma_pkg::ST_DN_PLACE;
            else state_in = lpt_ma_pkg::ST_DN_CMP;
         end
         lpt_ma_pkg::ST_DN_CMP: begin
            if (dn_stop) state_in = lpt_ma_pkg::ST_DN_PLACE;
            else state_in = lpt_ma_pkg::ST_DN_RD;
         end
         lpt_ma_pkg::ST_DN_PLACE: state_in = lpt_ma_pkg::ST_UP_RD;
         lpt_ma_pkg::ST_UP_RD: begin
            if (up_idx_ff == SW'(1)) state_in = lpt_ma_pkg::ST_UP_PLACE;
            else state_in = lpt_ma_pkg::ST_UP_CMP;
         end
         lpt_ma_pkg::ST_UP_CMP: begin
            if (up_move) state_in = lpt_ma_pkg::ST_UP_RD;
            else state_in = lpt_ma_pkg::ST_UP_PLACE;
         end
         lpt_ma_pkg::ST_UP_PLACE: begin
            if (rsp_free) state_in = lpt_ma_pkg::ST_IDLE;
         end
         default: state_in = lpt_ma_pkg::ST_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      fill_in       = fill_ff;
      init_k_in     = init_k_ff;
      init_n_in     = init_n_ff;
      parent_in     = parent_ff;
      child_in      = child_ff;
      up_idx_in     = up_idx_ff;
      len_in        = len_ff;
      mach_in       = mach_ff;
      start_in      = start_ff;
      finish_in     = finish_ff;
      ovf_in        = ovf_ff;
      last_in       = last_ff;
      rd_addr_a     = SW'(1);
      rd_addr_b     = SW'(1);
      wr_en         = 1'b0;
      wr_addr       = parent_ff;
      wr_data       = last_ff;
      rsp_mach_in   = rsp_mach_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_finish_in = rsp_finish_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      case (state_ff)
         lpt_ma_pkg::ST_INIT: begin
            wr_en     = 1'b1;
            wr_addr   = init_k_ff;
            wr_data   = '{mach: MachW'(init_k_ff), free_time: '0};
            init_k_in = init_k_ff + SW'(1);
         end
         lpt_ma_pkg::ST_IDLE: begin
            if (req_xfer) begin
               len_in = req_job_length;
               if (req_opcode == lpt_ma_pkg::OP_RESTART) begin
                  fill_in   = restart_n;
                  init_n_in = restart_n;
                  init_k_in = SW'(1);
               end
            end
         end
         lpt_ma_pkg::ST_POP_RD: begin
            rd_addr_a = SW'(1);
            rd_addr_b = fill_ff;
         end
         lpt_ma_pkg::ST_POP_LAT: begin
            mach_in   = rd_a_ff.mach;
            start_in  = rd_a_ff.free_time;
            last_in   = rd_b_ff;
            fill_in   = fill_ff - SW'(1);
            parent_in = SW'(1);
            child_in  = (SW+1)'(2);
         end
         lpt_ma_pkg::ST_DN_RD: begin
            rd_addr_a = child_ff[SW-1:0];
            rd_addr_b = child_has_sib ? (child_ff[SW-1:0] + SW'(1)) : child_ff[SW-1:0];
         end
         lpt_ma_pkg::ST_DN_CMP: begin
            if (!dn_stop) begin
               wr_en     = 1'b1;
               wr_addr   = parent_ff;
               wr_data   = sel_entry;
               parent_in = sel_idx;
               child_in  = {sel_idx, 1'b0};
            end
         end
         lpt_ma_pkg::ST_DN_PLACE: begin
            wr_en     = 1'b1;
            wr_addr   = parent_ff;
            wr_data   = last_ff;
            finish_in = sum[TimeW] ? '1 : sum[TimeW-1:0];
            ovf_in    = sum[TimeW];
            fill_in   = fill_ff + SW'(1);
            up_idx_in = fill_ff + SW'(1);
         end
         lpt_ma_pkg::ST_UP_RD: begin
            rd_addr_a = up_idx_ff >> 1;
         end
         lpt_ma_pkg::ST_UP_CMP: begin
            if (up_move) begin
               wr_en     = 1'b1;
               wr_addr   = up_idx_ff;
               wr_data   = rd_a_ff;
               up_idx_in = up_idx_ff >> 1;
            end
         end
         lpt_ma_pkg::ST_UP_PLACE: begin
            wr_en   = 1'b1;
            wr_addr = up_idx_ff;
            wr_data = '{mach: mach_ff, free_time: finish_ff};
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_mach_in   = mach_ff;
               rsp_start_in  = start_ff;
               rsp_finish_in = finish_ff;
               rsp_ovf_in    = ovf_ff;
            end
         end
         default: ;
      endcase
   end

   // heap RAM: one write, two registered reads
   always_ff @(posedge clock) begin
      if (wr_en) slot_mem[wr_addr] <= wr_data;
      rd_a_ff <= slot_mem[rd_addr_a];
      rd_b_ff <= slot_mem[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpt_ma_pkg::ST_INIT;
         count_ff     <= lpt_ma_pkg::COUNT_W'(lpt_ma_pkg::COUNT_RESET);
         fill_ff      <= SW'(InitReset);
         init_k_ff    <= SW'(1);
         init_n_ff    <= SW'(InitReset);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         init_k_ff    <= init_k_in;
         init_n_ff    <= init_n_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) count_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      parent_ff     <= parent_in;
      child_ff      <= child_in;
      up_idx_ff     <= up_idx_in;
      len_ff        <= len_in;
      mach_ff       <= mach_in;
      start_ff      <= start_in;
      finish_ff     <= finish_in;
      ovf_ff        <= ovf_in;
      last_ff       <= last_in;
      rsp_mach_ff   <= rsp_mach_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_finish_ff <= rsp_finish_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_machine_id  = rsp_mach_ff;
   assign rsp_start_time  = rsp_start_ff;
   assign rsp_finish_time = rsp_finish_ff;
   assign rsp_overflow    = rsp_ovf_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= 32'(MAX_MACHINES))
      else $error("heap fill above capacity");

   a_child_in_heap: assert property (@(posedge clock) disable iff (reset)
      state_ff == lpt_ma_pkg::ST_DN_CMP |-> child_ff <= {1'b0, fill_ff})
      else $error("sift-down compare past heap end");

   a_ovf_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ovf_ff |-> rsp_finish_ff == '1)
      else $error("overflow without saturated finish");

   a_finish_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_finish_ff >= rsp_start_ff)
      else $error("finish before start");

   a_job_starts: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_opcode == lpt_ma_pkg::OP_JOB && fill_ff != '0
      |=> state_ff == lpt_ma_pkg::ST_POP_RD)
      else $error("job transfer did not start delete-min");

endmodule

>>> sim/tb_lpt_machine_assigner_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LPT machine assigner core testbench
// Drives restart and job requests through a queue-fed driver with bursty
// timing against a stalling receiver, keeps its own min-heap of machines to
// predict every assignment, and checks each response field against it.
// Covers ties, empty heap, counts above the machine limit and deferred
// count changes.
// ----------------------------------------------------------------------------
module tb_lpt_machine_assigner_core;

   localparam int MAXM           = lpt_ma_pkg::MAX_MACHINES_DEF;
   localparam int MachW          = lpt_ma_pkg::MACH_W;
   localparam int TimeW          = lpt_ma_pkg::TIME_W;
   localparam int LenW           = lpt_ma_pkg::LEN_W;
   localparam int CountW         = lpt_ma_pkg::COUNT_W;
   localparam int SETTLE_CYCLES  = 100;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct {
      logic            op;
      logic [LenW-1:0] len;
   } sched_cmd_type;

   typedef struct {
      logic [MachW-1:0] mach;
      logic [TimeW-1:0] start;
      logic [TimeW-1:0] finish;
      logic             ovf;
   } grant_type;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_type;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_ready;
   logic                req_opcode     = lpt_ma_pkg::OP_RESTART;
   logic [LenW-1:0]     req_job_length = '0;
   logic                rsp_valid;
   logic                rsp_ready      = 1'b0;
   logic [MachW-1:0]    rsp_machine_id;
   logic [TimeW-1:0]    rsp_start_time;
   logic [TimeW-1:0]    rsp_finish_time;
   logic                rsp_overflow;
   logic                csr_we         = 1'b0;
   logic [CountW-1:0]   csr_wdata      = '0;

   // scheduler model state
   logic [MachW-1:0]    heap_mach [1:MAXM];
   logic [TimeW-1:0]    heap_time [1:MAXM];
   int unsigned         model_fill;
   logic [CountW-1:0]   cfg_count;

   sched_cmd_type       cmd_q[$];
   grant_type           grant_q[$];
   sched_cmd_type       drv_cmd;

   int                  issued_count   = 0;
   int                  accepted_count = 0;
   int                  burst_left     = 1;
   int                  gap_left       = 0;
   rx_mode_type         rx_mode        = RX_OPEN;
   int                  rx_left        = 0;
   int                  stall_cycles   = 0;

   int                  err_count      = 0;
   int                  n_restart      = 0;
   int                  n_job          = 0;
   int                  n_grant        = 0;
   int                  n_ovf          = 0;

   lpt_machine_assigner_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_job_length  (req_job_length),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_machine_id  (rsp_machine_id),
      .rsp_start_time  (rsp_start_time),
      .rsp_finish_time (rsp_finish_time),
      .rsp_overflow    (rsp_overflow),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   task automatic heap_refill();
      int n;
      n = (cfg_count > MAXM) ? MAXM : int'(cfg_count);
      for (int k = 1; k <= MAXM; k++) begin
         heap_mach[k] = (k <= n) ? MachW'(k) : '0;
         heap_time[k] = '0;
      end
      model_fill = n;
   endtask

   // delete-min, then re-insert the machine at its new free time
   task automatic predict_grant(input logic [LenW-1:0] len);
      logic [MachW-1:0] last_m;
      logic [TimeW-1:0] last_t;
      logic [TimeW:0]   sum;
      grant_type        g;
      int unsigned      p, c, i;
      bit               stop;
      if (model_fill != 0) begin
         g.mach  = heap_mach[1];
         g.start = heap_time[1];
         last_m  = heap_mach[model_fill];
         last_t  = heap_time[model_fill];
         model_fill--;
         p    = 1;
         c    = 2;
         stop = 1'b0;
         while (c <= model_fill && !stop) begin
            if (c < model_fill && heap_time[c] > heap_time[c+1])
               c++;
            if (last_t < heap_time[c]) begin
               stop = 1'b1;
            end else begin
               heap_mach[p] = heap_mach[c];
               heap_time[p] = heap_time[c];
               p = c;
               c = c * 2;
            end
         end
         heap_mach[p] = last_m;
         heap_time[p] = last_t;

         sum      = {1'b0, g.start} + (TimeW+1)'(len);
         g.ovf    = sum[TimeW];
         g.finish = g.ovf ? '1 : sum[TimeW-1:0];

         if (model_fill < MAXM) begin
            model_fill++;
            i = model_fill;
            while (i != 1 && g.finish < heap_time[i/2]) begin
               heap_mach[i] = heap_mach[i/2];
               heap_time[i] = heap_time[i/2];
               i = i / 2;
            end
            heap_mach[i] = g.mach;
            heap_time[i] = g.finish;
         end
         grant_q.push_back(g);
      end
   endtask

   task automatic check_grant();
      grant_type g;
      n_grant++;
      if (grant_q.size() == 0) begin
         $error("unexpected rsp transfer: machine_id %0d start %0d finish %0d",
                rsp_machine_id, rsp_start_time, rsp_finish_time);
         err_count++;
      end else begin
         g = grant_q.pop_front();
         if (rsp_overflow === 1'b1)
            n_ovf++;
         if (rsp_machine_id !== g.mach) begin
            $error("machine_id: expected %0d, actual %0d", g.mach, rsp_machine_id);
            err_count++;
         end
         if (rsp_start_time !== g.start) begin
            $error("start_time: expected %0d, actual %0d", g.start, rsp_start_time);
            err_count++;
         end
         if (rsp_finish_time !== g.finish) begin
            $error("finish_time: expected %0d, actual %0d", g.finish, rsp_finish_time);
            err_count++;
         end
         if (rsp_overflow !== g.ovf) begin
            $error("overflow: expected %0d, actual %0d", g.ovf, rsp_overflow);
            err_count++;
         end
      end
   endtask

   // monitor: sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            check_grant();
         if (req_valid && req_ready) begin
            accepted_count <= accepted_count + 1;
            if (req_opcode == lpt_ma_pkg::OP_RESTART) begin
               n_restart++;
               heap_refill();
            end else begin
               n_job++;
               predict_grant(req_job_length);
            end
         end
      end
   end

   // driver: bursts of transfers separated by random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (accepted_count == issued_count) begin
         if (gap_left != 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (cmd_q.size() != 0) begin
            drv_cmd = cmd_q.pop_front();
            req_valid      <= 1'b1;
            req_opcode     <= drv_cmd.op;
            req_job_length <= drv_cmd.len;
            issued_count   <= issued_count + 1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern switches randomly between four modes
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b1;
      end else begin
         if (rx_left == 0) begin
            rx_mode <= rx_mode_type'($urandom_range(0, 3));
            rx_left <= $urandom_range(8, 64);
         end else begin
            rx_left <= rx_left - 1;
         end
         case (rx_mode)
            RX_OPEN:   rsp_ready <= 1'b1;
            RX_COIN:   rsp_ready <= $urandom_range(0, 1);
            RX_SPARSE: rsp_ready <= ($urandom_range(0, 4) == 0);
            default:   rsp_ready <= (rx_left % 8) > 2;
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d assignments outstanding",
                  stall_cycles, grant_q.size());
         $display("[lpt_machine_assigner_core] ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic push_restart();
      sched_cmd_type c;
      c.op  = lpt_ma_pkg::OP_RESTART;
      c.len = 16'($urandom);
      cmd_q.push_back(c);
   endtask

   task automatic push_job(input logic [LenW-1:0] len);
      sched_cmd_type c;
      c.op  = lpt_ma_pkg::OP_JOB;
      c.len = len;
      cmd_q.push_back(c);
   endtask

   // wait until every request is taken and every assignment has arrived
   task automatic drain();
      while (cmd_q.size() != 0 || accepted_count != issued_count || req_valid
             || grant_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CountW-1:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      cfg_count = value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // restarts followed by longest-first job lists, mixed with loose noise
   task automatic random_phase(input logic [CountW-1:0] cnt, input int items);
      int left, pick, k, eff, step_max, dec, len;
      csr_write(cnt);
      eff  = (cnt > MAXM) ? MAXM : int'(cnt);
      left = items;
      while (left > 0) begin
         pick = $urandom_range(0, 19);
         if (pick < 15) begin
            push_restart();
            k   = $urandom_range(1, 2 * eff + 2);
            len = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 15);
            case ($urandom_range(0, 2))
               0:       step_max = 0;
               1:       step_max = 3;
               default: step_max = 4000;
            endcase
            for (int j = 0; j < k; j++) begin
               push_job(LenW'(len));
               dec = $urandom_range(0, step_max);
               len = (len > dec) ? len - dec : 0;
            end
            left -= k + 1;
         end else if (pick < 19) begin
            k = $urandom_range(1, 6);
            for (int j = 0; j < k; j++) begin
               if ($urandom_range(0, 3) == 0)
                  push_restart();
               else
                  push_job(16'($urandom));
            end
            left -= k;
         end else begin
            drain();
         end
      end
   endtask

   initial begin
      cfg_count = CountW'(lpt_ma_pkg::COUNT_RESET);
      heap_refill();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset heap of three machines: extremes and ties
      push_job(16'hFFFF);
      push_job(16'hFFFF);
      push_job(16'd100);
      push_job(16'd0);
      push_job(16'd1);

      // zero machines: jobs on an empty heap give nothing
      csr_write(7'd0);
      push_restart();
      push_job(16'd5);
      push_job(16'd0);

      // count above the machine limit clamps on restart
      csr_write(7'd127);
      push_restart();
      push_job(16'hFFFF);
      push_job(16'd0);

      // new count has no effect until the next restart
      csr_write(7'd2);
      push_job(16'd7);
      push_job(16'd7);
      push_restart();
      push_job(16'd3);
      push_job(16'd3);
      push_job(16'd3);

      csr_write(7'd64);
      push_restart();
      push_job(16'd1);

      random_phase(7'd1, 50);
      random_phase(7'd2, 50);
      random_phase(7'd64, 100);
      random_phase(7'd127, 80);
      random_phase(7'd65, 60);
      random_phase(CountW'($urandom_range(3, 63)), 60);
      random_phase(CountW'($urandom_range(1, 127)), 60);
      random_phase(7'd5, 50);
      drain();

      $display("covered %0d restarts and %0d jobs, %0d assignments checked, %0d saturated",
               n_restart, n_job, n_grant, n_ovf);
      $display("machine counts from 0 to 127, ties, empty heap and deferred count changes");
      if (err_count == 0) begin
         $display("[lpt_machine_assigner_core] OK");
      end else begin
         $display("[lpt_machine_assigner_core] ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
design/lpt_ma_pkg.sv
design/lpt_machine_assigner_core.sv
sim/tb_lpt_machine_assigner_core.sv
